// ----- rtl/core/slt_pkg.sv -----
// slt_pkg: command and status codes, the classified operation type and the
// queue entry shared by the front, the queue and the back of sorted_list_table
// no dependencies
package slt_pkg;

    localparam int CMD_W        = 3;
    localparam int VALUE_W      = 32;
    localparam int POSITION_W   = 8;
    localparam int STATUS_W     = 2;
    localparam int ELEM_COUNT_W = 9;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_CONTAINS,
        OP_GET,
        OP_REMOVE,
        OP_REVERSE,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                          op;
        logic signed [VALUE_W-1:0]    value;
        logic        [POSITION_W-1:0] position;
    } item_t;

endpackage

// ----- rtl/core/slt_if.sv -----
// slt_if: request and result channel interfaces of sorted_list_table
// depends on slt_pkg
interface slt_req_if
    import slt_pkg::*;
    ;
    logic                          valid;
    logic                          ready;
    logic        [CMD_W-1:0]       command;
    logic signed [VALUE_W-1:0]     value;
    logic        [POSITION_W-1:0]  position;

    modport source (output valid, command, value, position, input ready);
    modport sink (input valid, command, value, position, output ready);
endinterface

interface slt_rsp_if
    import slt_pkg::*;
    ;
    logic                            valid;
    logic                            ready;
    logic        [STATUS_W-1:0]      status;
    logic                            found;
    logic signed [VALUE_W-1:0]       data;
    logic        [ELEM_COUNT_W-1:0]  element_count;

    modport source (output valid, status, found, data, element_count, input ready);
    modport sink (input valid, status, found, data, element_count, output ready);
endinterface

// ----- rtl/core/slt_front.sv -----
// slt_front: accepts request words and classifies the command into an operation
// depends on slt_pkg, slt_if
module slt_front
    import slt_pkg::*;
(
    slt_req_if.sink request,
    output logic    push,
    output item_t   push_item,
    input  logic    full
);

    op_t op;

    always_comb
    begin
        case (request.command)
            CMD_INSERT:   op = OP_INSERT;
            CMD_CONTAINS: op = OP_CONTAINS;
            CMD_GET:      op = OP_GET;
            CMD_REMOVE:   op = OP_REMOVE;
            CMD_REVERSE:  op = OP_REVERSE;
            default:      op = OP_NOP;
        endcase
    end

    assign request.ready      = !full;
    assign push               = request.valid && !full;
    assign push_item.op       = op;
    assign push_item.value    = request.value;
    assign push_item.position = request.position;

endmodule

// ----- rtl/core/slt_queue.sv -----
// slt_queue: short fifo of classified words between front and back
// depends on slt_pkg
module slt_queue
    import slt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t          entry_reg [QUEUE_DEPTH];
    logic [QW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == QCW'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/slt_back.sv -----
// slt_back: element memory, count, order flag and the sequencer that carries
// out each operation, with the result output register
// depends on slt_pkg, slt_if
module slt_back
    import slt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  item_t     head,
    output logic      pop,
    slt_rsp_if.source result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = ELEM_COUNT_W;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SCAN_RD  = 8'b0000_0010,
        ST_SCAN_CMP = 8'b0000_0100,
        ST_SHIFT_RD = 8'b0000_1000,
        ST_SHIFT_WR = 8'b0001_0000,
        ST_PUT      = 8'b0010_0000,
        ST_GET_WAIT = 8'b0100_0000,
        ST_FIN      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;
    logic [AW-1:0]      mem_raddr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rev_reg, rev_next;
    item_t         item_reg, item_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic          up_reg, up_next;

    logic [STATUS_W-1:0]      res_status_reg, res_status_next;
    logic                     res_found_reg, res_found_next;
    logic signed [VALUE_W-1:0] res_data_reg, res_data_next;

    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       out_status_reg, out_status_next;
    logic                      out_found_reg, out_found_next;
    logic signed [VALUE_W-1:0] out_data_reg, out_data_next;
    logic [NW-1:0]             out_count_reg, out_count_next;

    logic [NW-1:0] cnt_w;
    logic [NW-1:0] head_pos_w;
    logic [AW-1:0] head_phys;
    logic [NW-1:0] idx_w;
    logic [AW-1:0] scan_phys;
    logic          scan_last;
    logic [NW-1:0] at_w;
    logic [NW-1:0] p_w;
    logic [AW-1:0] nidx;

    assign cnt_w      = NW'(cnt_reg);
    assign head_pos_w = NW'(head.position);
    assign head_phys  = rev_reg ? AW'(cnt_w - head_pos_w - NW'(1)) : AW'(head.position);
    assign idx_w      = NW'(idx_reg);
    assign scan_phys  = rev_reg ? AW'(cnt_w - idx_w - NW'(1)) : idx_reg;
    assign scan_last  = (idx_w + NW'(1) == cnt_w);
    assign nidx       = up_reg ? idx_reg - AW'(1) : idx_reg + AW'(1);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rev_next        = rev_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        up_next         = up_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        pop             = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        at_w            = '0;
        p_w             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop             = 1'b1;
                    item_next       = head;
                    res_status_next = STATUS_OK;
                    res_found_next  = 1'b0;
                    res_data_next   = '0;
                    idx_next        = '0;
                    state_next      = ST_FIN;
                    case (head.op)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else if (cnt_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        OP_CONTAINS:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        OP_GET:
                        begin
                            if (head_pos_w >= cnt_w)
                            begin
                                res_status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                mem_raddr  = head_phys;
                                state_next = ST_GET_WAIT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (head_pos_w >= cnt_w)
                            begin
                                res_status_next = STATUS_RANGE;
                            end
                            else if (NW'(head_phys) + NW'(1) == cnt_w)
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                            else
                            begin
                                idx_next   = head_phys;
                                up_next    = 1'b0;
                                state_next = ST_SHIFT_RD;
                            end
                        end
                        OP_REVERSE:
                        begin
                            rev_next = !rev_reg;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                mem_raddr  = scan_phys;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (item_reg.op == OP_CONTAINS)
                begin
                    if (rdata_reg == item_reg.value)
                    begin
                        res_found_next = 1'b1;
                        state_next     = ST_FIN;
                    end
                    else if (scan_last)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
                else
                begin
                    if (!($signed(rdata_reg) < item_reg.value) || scan_last)
                    begin
                        at_w     = (!($signed(rdata_reg) < item_reg.value)) ? idx_w : cnt_w;
                        p_w      = rev_reg ? cnt_w - at_w : at_w;
                        pos_next = AW'(p_w);
                        idx_next = AW'(cnt_w);
                        up_next  = 1'b1;
                        if (p_w == cnt_w)
                        begin
                            state_next = ST_PUT;
                        end
                        else
                        begin
                            state_next = ST_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                mem_raddr  = up_reg ? idx_reg - AW'(1) : idx_reg + AW'(1);
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rdata_reg;
                idx_next  = nidx;
                if (up_reg)
                begin
                    state_next = (nidx == pos_reg) ? ST_PUT : ST_SHIFT_RD;
                end
                else if (NW'(nidx) + NW'(1) == cnt_w)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = item_reg.value;
                cnt_next   = cnt_reg + CW'(1);
                state_next = ST_FIN;
            end
            ST_GET_WAIT:
            begin
                res_data_next = rdata_reg;
                state_next    = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_data_next   = res_data_reg;
                    out_count_next  = cnt_w;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        up_reg         <= up_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.found         = out_found_reg;
    assign result.data          = out_data_reg;
    assign result.element_count = out_count_reg;

endmodule

// ----- rtl/core/sorted_list_table.sv -----
// sorted_list_table: ordered store of signed 32-bit values
// depends on slt_pkg, slt_if, slt_front, slt_queue, slt_back
//
// request carries command, value and position; result carries status, found,
// data and element_count, one result word for every request word, in order.
// the front takes a request word whenever the two-entry queue has room;
// while the back works or a result waits, request.ready falls only when full.
// the back keeps the elements in a memory with one registered read port and
// carries out one word at a time; the reverse command flips an order flag,
// so it moves no data. steps per word, counted from leaving the queue:
//   reverse, contains on empty, errors, unused codes: only the result
//   get: one read, then the result
//   contains: a read and a compare per element compared
//   insert: the same per element compared, a read and a write per element moved up
//   remove: a read and a write per element moved down
// insert ends with a write of the new value. each step reads one element
// from the registered port and then uses its data.
// the result register holds the word while result.ready is low; the back then
// waits with its next result, and the queue keeps taking requests until full.
// reset empties the store and the queue and clears the order flag; the memory
// itself needs no clearing since only positions below the count are read.
module sorted_list_table
    import slt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    slt_req_if.sink   request,
    slt_rsp_if.source result
);

    logic  push;
    item_t push_item;
    logic  full;
    logic  pop;
    item_t pop_item;
    logic  empty;

    slt_front u_front (
        .request   (request),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    slt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    slt_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (pop_item),
        .pop    (pop),
        .result (result)
    );

endmodule

// ----- rtl/core/slt_checker.sv -----
// slt_checker: port-level assertions for sorted_list_table, with its bind
// depends on slt_pkg
module slt_checker
    import slt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [STATUS_W-1:0]       rsp_status,
    input logic                      rsp_found,
    input logic [VALUE_W-1:0]        rsp_data,
    input logic [ELEM_COUNT_W-1:0]   rsp_count
);

    // stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found)
            && $stable(rsp_data) && $stable(rsp_count))
        else $error("result word changed while stalled");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= ELEM_COUNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STATUS_FULL |-> rsp_count == ELEM_COUNT_W'(CAPACITY))
        else $error("full status with room left");

    a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STATUS_RANGE |-> !rsp_found && rsp_data == '0)
        else $error("out of range word carries data");

    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_status == STATUS_OK && rsp_data == '0)
        else $error("found word carries status or data");

endmodule

bind sorted_list_table slt_checker #(
    .CAPACITY (CAPACITY)
) u_slt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (result.valid),
    .rsp_ready  (result.ready),
    .rsp_status (result.status),
    .rsp_found  (result.found),
    .rsp_data   (result.data),
    .rsp_count  (result.element_count)
);
